@@ src/rfe_pkg.sv @@
// Shared types, constants and the FCS helper for the RFCOMM frame encoder.
package rfe_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] UihCode     = 8'hEF;
  localparam logic [7:0] UihMask     = 8'hEF;
  localparam logic [7:0] CrcInit     = 8'hFF;
  localparam logic [7:0] CrcPolyRefl = 8'hE0;

  localparam int unsigned InDataW = 40;

  typedef struct packed {
    logic       is_data;
    logic       last;
    logic [7:0] byte0;
    logic [7:0] ctrl;
    logic [7:0] lbyte;
    logic       has_credit;
    logic [7:0] credit;
  } rfe_cmd_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPolyRefl) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ src/rfcomm_frame_encoder_core.sv @@
// Top level of the RFCOMM frame encoder with 8-bit FCS.
// Start items (tuser 0) open a frame and produce address, control, length,
// optional credit and, for an empty payload, the FCS byte; payload items
// (tuser 1) pass their byte through, and the last one is followed by the FCS
// byte flagged with tlast. Payload with no open frame is dropped. The output
// runs at one byte per cycle, set by the byte sequencer, while the receiver
// keeps m_axis_tready high and the queue holds commands. Input and output are
// decoupled by a QUEUE_DEPTH entry command queue, so payload is taken at one
// byte per cycle while the queue has room.
module rfcomm_frame_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = rfe_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,     // ea_bit
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // dlci_channel, direction_bit, cr_bit, frame_type, pf_bit, payload_length,
  // has_credit, credit_value, data_byte
  input  logic [rfe_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,   // func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // out_byte
  output logic                        m_axis_tlast    // frame_end
);
  import rfe_pkg::*;

  logic     ea_q;
  logic     q_full, q_push, q_pop, q_valid;
  rfe_cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ea_q <= 1'b1;
    end else if (cfg_valid_i) begin
      ea_q <= cfg_data_i;
    end
  end

  rfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ea_bit_i      (ea_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  rfe_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  rfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_i        (head_cmd),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ src/rfe_front.sv @@
// Front end: accepts items, builds header commands and filters stray payload.
module rfe_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ea_bit_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rfe_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output rfe_pkg::rfe_cmd_t           q_cmd_o
);
  import rfe_pkg::*;

  logic [6:0] rem_q, rem_d;
  logic [4:0] dlci;
  logic [6:0] len;
  logic       xfer;

  assign dlci = s_axis_tdata[4:0];
  assign len  = s_axis_tdata[22:16];

  assign s_axis_tready = !q_full_i;
  assign xfer          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cmd_o.is_data    = s_axis_tuser;
    q_cmd_o.ctrl       = s_axis_tdata[14:7] | {3'b000, s_axis_tdata[15], 4'b0000};
    q_cmd_o.lbyte      = {len, 1'b1};
    q_cmd_o.has_credit = s_axis_tdata[23];
    q_cmd_o.credit     = s_axis_tdata[31:24];
    rem_d              = rem_q;
    q_push_o           = 1'b0;
    if (s_axis_tuser) begin
      q_cmd_o.byte0 = s_axis_tdata[39:32];
      q_cmd_o.last  = (rem_q == 7'd1);
      if (xfer && rem_q != 7'd0) begin
        q_push_o = 1'b1;
        rem_d    = rem_q - 7'd1;
      end
    end else begin
      q_cmd_o.byte0 = {dlci, s_axis_tdata[5], s_axis_tdata[6], ea_bit_i};
      q_cmd_o.last  = (len == 7'd0);
      if (xfer) begin
        q_push_o = 1'b1;
        rem_d    = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

@@ src/rfe_fifo.sv @@
// Short command queue between front end and byte sequencer.
module rfe_fifo #(
  parameter int unsigned Depth = rfe_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rfe_pkg::rfe_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rfe_pkg::rfe_cmd_t cmd_o
);
  import rfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rfe_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/rfe_back.sv @@
// Byte sequencer: emits header, payload and FCS bytes and keeps the FCS register.
module rfe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  rfe_pkg::rfe_cmd_t head_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tlast
);
  import rfe_pkg::*;

  localparam logic [2:0] PhHead   = 3'd0;
  localparam logic [2:0] PhCtrl   = 3'd1;
  localparam logic [2:0] PhLen    = 3'd2;
  localparam logic [2:0] PhCredit = 3'd3;
  localparam logic [2:0] PhFcs    = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [7:0] fcs_q, fcs_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       out_free, load;

  assign out_free      = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = byte_q;
  assign m_axis_tlast  = last_q;

  always_comb begin
    phase_d = phase_q;
    fcs_d   = fcs_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    byte_d  = byte_q;
    last_d  = 1'b0;
    if (head_valid_i && out_free) begin
      load = 1'b1;
      case (phase_q)
        PhHead: begin
          byte_d = head_i.byte0;
          if (head_i.is_data) begin
            if (head_i.last) begin
              phase_d = PhFcs;
            end else begin
              pop_o = 1'b1;
            end
          end else begin
            fcs_d   = crc8_byte(CrcInit, head_i.byte0);
            phase_d = PhCtrl;
          end
        end
        PhCtrl: begin
          byte_d  = head_i.ctrl;
          fcs_d   = crc8_byte(fcs_q, head_i.ctrl);
          phase_d = PhLen;
        end
        PhLen: begin
          byte_d = head_i.lbyte;
          if ((head_i.ctrl & UihMask) != UihCode) begin
            fcs_d = crc8_byte(fcs_q, head_i.lbyte);
          end
          if (head_i.has_credit) begin
            phase_d = PhCredit;
          end else if (head_i.last) begin
            phase_d = PhFcs;
          end else begin
            pop_o   = 1'b1;
            phase_d = PhHead;
          end
        end
        PhCredit: begin
          byte_d = head_i.credit;
          if (head_i.last) begin
            phase_d = PhFcs;
          end else begin
            pop_o   = 1'b1;
            phase_d = PhHead;
          end
        end
        PhFcs: begin
          byte_d  = ~fcs_q;
          last_d  = 1'b1;
          fcs_d   = CrcInit;
          pop_o   = 1'b1;
          phase_d = PhHead;
        end
        default: begin
          load    = 1'b0;
          phase_d = PhHead;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead;
      fcs_q   <= CrcInit;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fcs_q   <= fcs_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

endmodule

@@ tb/rfcomm_frame_encoder_core_tb.sv @@
// Self-checking testbench for the RFCOMM frame encoder: directed rows, then random frames.
`timescale 1ns / 1ps

module rfcomm_frame_encoder_core_tb;
  import rfe_pkg::*;

  localparam logic FuncStart   = 1'b0;
  localparam logic FuncPayload = 1'b1;

  typedef struct {
    logic              func;
    logic [InDataW-1:0] bits;
    int                known_n;   // -1: take the bytes from the encoder model
    logic [31:0]       known;     // typed bytes, first byte lowest
  } stim_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i    = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tlast;

  // model state
  logic       ea_q   = 1'b1;
  logic [7:0] fcs_q  = CrcInit;
  logic [6:0] left_q = '0;
  logic       open_q = 1'b0;

  logic [8:0] frame_bytes_due[$];   // {frame_end, out_byte}
  int         mismatches = 0;
  int         burst_left = 1;
  int         gap_max    = 0;
  int         rx_cnt     = 0;
  int         rx_period  = 1;
  int         rx_stall   = 0;
  stim_row_t  directed[$];

  rfcomm_frame_encoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // bit-serial reflected CRC-8
  function automatic logic [7:0] fcs_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CrcPolyRefl;
    end
    return r;
  endfunction

  function automatic logic [InDataW-1:0] hdr_bits(
    input logic [4:0] dlci, input logic dir, input logic cr, input logic [7:0] ftype,
    input logic pf, input logic [6:0] len, input logic cen, input logic [7:0] credit,
    input logic [7:0] data);
    return {data, credit, cen, len, pf, ftype, cr, dir, dlci};
  endfunction

  function automatic stim_row_t row(input logic func, input logic [InDataW-1:0] bits,
                                    input int kn, input logic [31:0] known);
    stim_row_t r;
    r.func    = func;
    r.bits    = bits;
    r.known_n = kn;
    r.known   = known;
    return r;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic last, input bit push_en);
    if (push_en) frame_bytes_due.push_back({last, b});
  endfunction

  // Frame encoder model: returns the number of output bytes the item causes.
  function automatic int encode_item(input logic func, input logic [InDataW-1:0] d,
                                     input bit push_en);
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] lbyte;
    logic [7:0] acc;
    int         n;
    n = 0;
    if (func == FuncStart) begin
      addr  = {d[4:0], d[5], d[6], ea_q};
      ctrl  = d[14:7] | {3'b000, d[15], 4'b0000};
      lbyte = {d[22:16], 1'b1};
      acc   = fcs_update(CrcInit, addr);
      acc   = fcs_update(acc, ctrl);
      if ((ctrl & UihMask) != UihCode) acc = fcs_update(acc, lbyte);
      emit(addr, 1'b0, push_en);
      emit(ctrl, 1'b0, push_en);
      emit(lbyte, 1'b0, push_en);
      n = 3;
      if (d[23]) begin
        emit(d[31:24], 1'b0, push_en);
        n++;
      end
      if (d[22:16] == 7'd0) begin
        emit(8'hFF - acc, 1'b1, push_en);
        n++;
        fcs_q  = CrcInit;
        left_q = '0;
        open_q = 1'b0;
      end else begin
        fcs_q  = acc;
        left_q = d[22:16];
        open_q = 1'b1;
      end
      return n;
    end
    if (!open_q || left_q == 7'd0) return 0;
    emit(d[39:32], 1'b0, push_en);
    n      = 1;
    left_q = left_q - 7'd1;
    if (left_q == 7'd0) begin
      emit(8'hFF - fcs_q, 1'b1, push_en);
      n++;
      fcs_q  = CrcInit;
      open_q = 1'b0;
    end
    return n;
  endfunction

  // called at a rising edge; returns at a rising edge
  task automatic send_item(input logic func, input logic [InDataW-1:0] d, input bit push_en,
                           output int n);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= func;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    n = encode_item(func, d, push_en);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // called at a rising edge
  task automatic cfg_write(input logic ea);
    s_axis_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    // let the queue settle; dropped payload is never pushed into the queue
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ea;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ea_q = ea;
  endtask

  // receiver stalls on a periodic pattern; the period and stall length are re-chosen at random
  always @(posedge clk_i) begin
    rx_cnt++;
    if (rx_cnt % 64 == 0) begin
      rx_period = $urandom_range(2, 9);
      rx_stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
    end
    m_axis_tready <= (rx_cnt % rx_period) >= rx_stall;
  end

  // output transfer happens at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        if (m_axis_tdata !== frame_bytes_due[0][7:0])
          report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata,
                                    frame_bytes_due[0][7:0]));
        if (m_axis_tlast !== frame_bytes_due[0][8])
          report_mismatch($sformatf("frame_end %b, want %b", m_axis_tlast,
                                    frame_bytes_due[0][8]));
        void'(frame_bytes_due.pop_front());
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int         n;
    int         cnt;
    int         frames;
    int         len;
    int         cut;
    logic [7:0] ftype;

    // stray payload with every unused bit set
    directed.push_back(row(FuncPayload, hdr_bits(31, 1, 1, 8'hFF, 1, 127, 1, 8'hFF, 8'hAA),
                           0, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(0, 0, 0, 8'h00, 0, 1, 0, 8'h00, 8'h00),
                           3, 32'h0003_0001));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(31, 1, 1, 8'hFF, 1, 127, 1, 8'hFF, 8'hFF),
                           4, 32'hFFFF_FFFF));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'hFF),
                           -1, 32'h0));
    // abandons the open frame; empty UIH with credit
    directed.push_back(row(FuncStart, hdr_bits(0, 0, 0, UihCode, 0, 0, 1, 8'h00, 8'h55),
                           -1, 32'h0));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'h12),
                           0, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(5, 0, 1, UihCode, 1, 0, 0, 8'h00, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(1, 0, 1, 8'h2F, 1, 0, 0, 8'h00, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(9, 1, 0, 8'h43, 0, 0, 1, 8'h80, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(2, 1, 0, UihCode, 0, 2, 0, 8'h00, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'h5A),
                           -1, 32'h0));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'hA5),
                           -1, 32'h0));
    // one byte beyond the announced length
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'h11),
                           0, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(16, 0, 1, 8'h63, 1, 3, 1, 8'h07, 8'hC3),
                           -1, 32'h0));
    directed.push_back(row(FuncPayload, hdr_bits(21, 1, 0, 8'h3C, 1, 99, 1, 8'hA0, 8'h80),
                           -1, 32'h0));
    directed.push_back(row(FuncStart, hdr_bits(30, 1, 1, 8'h0F, 0, 1, 0, 8'h00, 8'h00),
                           -1, 32'h0));
    directed.push_back(row(FuncPayload, hdr_bits(0, 0, 0, 8'h00, 0, 0, 0, 8'h00, 8'h7F),
                           -1, 32'h0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_max = 3;
    foreach (directed[i]) begin
      for (int k = 0; k < directed[i].known_n; k++)
        frame_bytes_due.push_back({1'b0, directed[i].known[8*k +: 8]});
      send_item(directed[i].func, directed[i].bits, directed[i].known_n < 0, n);
    end

    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(ph[0]);
      case (ph)
        0: gap_max = 0;
        1: gap_max = 3;
        2: gap_max = 8;
        default: gap_max = 2;
      endcase
      cnt    = 0;
      frames = 0;
      while (cnt < 95) begin
        if ($urandom_range(0, 99) < 8) begin
          send_item(FuncPayload, InDataW'({$urandom(), $urandom()}), 1'b1, n);
          cnt++;
        end else begin
          if (ph == 1 && frames == 0) len = 127;
          else if ($urandom_range(0, 39) == 0) len = $urandom_range(0, 127);
          else len = $urandom_range(0, 6);
          case ($urandom_range(0, 3))
            0, 1: ftype = UihCode;
            2: ftype = 8'h2F;
            default: ftype = 8'($urandom());
          endcase
          send_item(FuncStart,
                    hdr_bits(5'($urandom()), 1'($urandom()), 1'($urandom()), ftype,
                             1'($urandom()), 7'(len), 1'($urandom()), 8'($urandom()),
                             8'($urandom())), 1'b1, n);
          cnt++;
          frames++;
          case ($urandom_range(0, 9))
            0: cut = $urandom_range(0, len);
            1: cut = len + 1;
            default: cut = len;
          endcase
          for (int k = 0; k < cut; k++) begin
            send_item(FuncPayload, InDataW'({$urandom(), $urandom()}), 1'b1, n);
            cnt++;
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ rfcomm_frame_encoder_core.f @@
src/rfe_pkg.sv
src/rfe_front.sv
src/rfe_fifo.sv
src/rfe_back.sv
src/rfcomm_frame_encoder_core.sv
tb/rfcomm_frame_encoder_core_tb.sv
